[rtl/wcm_pkg.sv]
// shared types and constants for the wildcard matcher
`default_nettype none

package wcm_pkg;

  localparam int unsigned MaxPatternDef = 64;

  localparam logic [7:0] StarByte = 8'h2A;
  localparam logic [7:0] AnyByte  = 8'h3F;

  typedef enum logic [1:0] {
    CmdAppend  = 2'd0,
    CmdFinish  = 2'd1,
    CmdText    = 2'd2,
    CmdRestart = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic match;
    logic overflow;
  } out_t;

endpackage

`default_nettype wire

[rtl/wcm_scan.sv]
// log-depth segmented prefix-or: sum[i] = gen[i] | prop[i] & sum[i-1]
`default_nettype none

module wcm_scan #(
  parameter int unsigned Width = wcm_pkg::MaxPatternDef + 1
) (
  input  wire logic [Width-1:0] gen_i,
  input  wire logic [Width-1:0] prop_i,
  output logic      [Width-1:0] sum_o
);

  localparam int unsigned Levels = (Width > 1) ? $clog2(Width) : 1;

  logic [Width-1:0] g_lvl [Levels+1];
  logic [Width-1:0] p_lvl [Levels];

  assign g_lvl[0] = gen_i;
  assign p_lvl[0] = prop_i;

  for (genvar l = 0; l < Levels; l++) begin : g_level
    localparam int unsigned Dist = 1 << l;
    for (genvar i = 0; i < Width; i++) begin : g_bit
      if (i >= Dist) begin : g_comb
        assign g_lvl[l+1][i] = g_lvl[l][i] | (p_lvl[l][i] & g_lvl[l][i-Dist]);
        if (l + 1 < Levels) begin : g_prop
          assign p_lvl[l+1][i] = p_lvl[l][i] & p_lvl[l][i-Dist];
        end
      end else begin : g_pass
        assign g_lvl[l+1][i] = g_lvl[l][i];
        if (l + 1 < Levels) begin : g_prop
          assign p_lvl[l+1][i] = p_lvl[l][i];
        end
      end
    end
  end

  assign sum_o = g_lvl[Levels];

endmodule

`default_nettype wire

[rtl/wildcard_match_dp.sv]
// streaming wildcard matcher: pattern store, match row and handshake stages
// a transaction waits in the input stage, then its result is registered
// throughput: one transaction per cycle unless a result stalls; the row update is a
//   log-depth prefix-or over all pattern positions between input and result register
// append transactions produce no result; finish, text and restart produce one
// reset: pattern count, flags and stages cleared, row set to empty text;
//   the pattern store itself is not cleared
`default_nettype none

module wildcard_match_dp #(
  parameter int unsigned MaxPattern = wcm_pkg::MaxPatternDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire wcm_pkg::in_t in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output wcm_pkg::out_t    out_data_o
);

  localparam int unsigned RowW  = MaxPattern + 1;
  localparam int unsigned CntW  = $clog2(MaxPattern + 1);
  localparam int unsigned AddrW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  // input stage
  logic         in_valid_q;
  wcm_pkg::in_t in_q;

  // matcher state
  logic [CntW-1:0] count_q, count_d;
  logic            loading_q, loading_d;
  logic            overflow_q, overflow_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RowW-1:0] empty_q, empty_d;

  // pattern store, one entry per position
  logic [7:0]            pat_q [MaxPattern];
  logic [MaxPattern-1:0] star_q;
  logic [MaxPattern-1:0] any_q;

  // result stage
  logic          out_valid_q, out_valid_d;
  wcm_pkg::out_t out_q, out_d;

  logic              out_ready;
  logic              is_append;
  logic              fire;
  wcm_pkg::cmd_e     cmd;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [CntW-1:0]   base_cnt;
  logic [CntW-1:0]   next_cnt;
  logic [RowW-1:0]   old_row;
  logic [RowW-1:0]   scan_gen;
  logic [RowW-1:0]   scan_prop;
  logic [RowW-1:0]   text_row;

  assign cmd       = wcm_pkg::cmd_e'(in_q.command);
  assign out_ready = !out_valid_q || !out_stall_i;
  assign is_append = (cmd == wcm_pkg::CmdAppend);
  assign fire      = in_valid_q && (is_append || out_ready);
  assign in_stall_o = in_valid_q && !fire;

  // a text byte during loading starts from the empty-text row
  assign old_row = loading_q ? empty_q : row_q;

  assign scan_gen[0]  = 1'b0;
  assign scan_prop[0] = 1'b0;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_pos
    localparam logic [CntW-1:0] Pos = CntW'(k);
    logic active;
    logic hit;
    assign active = (Pos < count_q);
    assign hit    = any_q[k] || (pat_q[k] == in_q.symbol);
    // star rule wins over the diagonal rule, also for a literal star in the text
    assign scan_gen[k+1]  = active &&
                            (star_q[k] ? old_row[k+1] : (hit && old_row[k]));
    assign scan_prop[k+1] = active && star_q[k];
  end

  wcm_scan #(
    .Width(RowW)
  ) u_scan (
    .gen_i (scan_gen),
    .prop_i(scan_prop),
    .sum_o (text_row)
  );

  always_comb begin
    count_d    = count_q;
    loading_d  = loading_q;
    overflow_d = overflow_q;
    row_d      = row_q;
    empty_d    = empty_q;
    wr_en      = 1'b0;
    base_cnt   = loading_q ? count_q : '0;
    next_cnt   = base_cnt + CntW'(1);
    wr_addr    = base_cnt[AddrW-1:0];
    out_d      = out_q;

    if (fire) begin
      unique case (cmd)
        wcm_pkg::CmdAppend: begin
          loading_d = 1'b1;
          if (!loading_q) begin
            overflow_d = 1'b0;
            empty_d    = RowW'(1);
          end
          if (base_cnt < CntW'(MaxPattern)) begin
            wr_en             = 1'b1;
            count_d           = next_cnt;
            empty_d[next_cnt] = empty_d[base_cnt] && (in_q.symbol == wcm_pkg::StarByte);
          end else begin
            overflow_d = 1'b1;
          end
        end
        wcm_pkg::CmdText: begin
          loading_d      = 1'b0;
          row_d          = text_row;
          out_d.match    = text_row[count_q];
          out_d.overflow = overflow_q;
        end
        wcm_pkg::CmdFinish, wcm_pkg::CmdRestart: begin
          loading_d      = 1'b0;
          row_d          = empty_q;
          out_d.match    = empty_q[count_q];
          out_d.overflow = overflow_q;
        end
        default: begin
          loading_d = loading_q;
        end
      endcase
    end

    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = fire && !is_append;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      loading_q   <= 1'b0;
      overflow_q  <= 1'b0;
      row_q       <= RowW'(1);
      empty_q     <= RowW'(1);
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      loading_q   <= loading_d;
      overflow_q  <= overflow_d;
      row_q       <= row_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !is_append) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pat_q[wr_addr]  <= in_q.symbol;
      star_q[wr_addr] <= (in_q.symbol == wcm_pkg::StarByte);
      any_q[wr_addr]  <= (in_q.symbol == wcm_pkg::AnyByte);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPattern))
    else $error("pattern count above capacity");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> (count_q == CntW'(MaxPattern)))
    else $error("overflow flagged with room left in the pattern");

  a_empty_bit0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q[0])
    else $error("empty-text row lost its first bit");

  a_text_clears_bit0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd == wcm_pkg::CmdText) |=> !row_q[0])
    else $error("row bit zero set after a text transaction");

  a_rebuild_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (cmd == wcm_pkg::CmdFinish || cmd == wcm_pkg::CmdRestart))
      |=> (row_q == empty_q) && !loading_q)
    else $error("finish or restart did not rebuild the row");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && !is_append))
    else $error("result without a finish, text or restart transaction");

endmodule

`default_nettype wire
